// ===== rtl/core/mm4_pkg.sv =====
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = DIM * DIM;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 2 * VAL_W + 2;

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [IDX_W-1:0]        index_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MAC,
        ST_EMIT
    } state_t;

    // Control from the sequencer to each MAC cell.
    typedef struct packed {
        logic clear;
        logic step;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/mm4_cell.sv =====
// ----------------------------------------------------------------------------
// mm4_cell
// One multiply-accumulate cell: forms one dot product over DIM steps and
// holds the saturated Q16.16 result in a shift chain toward the output.
// ----------------------------------------------------------------------------
module mm4_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  mm4_pkg::cell_ctrl_t ctrl,
    input  mm4_pkg::value_t    a_val,
    input  mm4_pkg::value_t    b_val,
    input  logic               load_out,
    input  logic               shift_out,
    input  mm4_pkg::value_t    chain_val,
    input  logic               chain_ovf,
    output mm4_pkg::value_t    out_val,
    output logic               out_ovf
);
    import mm4_pkg::*;

    logic signed [2*VAL_W-1:0] prod_reg;
    logic                      prod_vld_reg;
    acc_t                      acc_reg;
    value_t                    res_reg;
    logic                      ovf_reg;
    acc_t                      shifted;
    logic                      pos_ovf;
    logic                      neg_ovf;
    value_t                    sat_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.step;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_val * b_val;
        if (ctrl.clear)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if (load_out)
        begin
            res_reg <= sat_val;
            ovf_reg <= pos_ovf | neg_ovf;
        end
        else if (shift_out)
        begin
            res_reg <= chain_val;
            ovf_reg <= chain_ovf;
        end
    end

    // Floor by arithmetic shift, then saturate to 32 bits.
    always_comb
    begin
        shifted = acc_reg >>> FRAC_BITS;
        pos_ovf = !shifted[ACC_W-1] && (shifted[ACC_W-2:VAL_W-1] != '0);
        neg_ovf = shifted[ACC_W-1] && (shifted[ACC_W-2:VAL_W-1] != '1);
        if (pos_ovf)
            sat_val = {1'b0, {(VAL_W-1){1'b1}}};
        else if (neg_ovf)
            sat_val = {1'b1, {(VAL_W-1){1'b0}}};
        else
            sat_val = shifted[VAL_W-1:0];
    end

    assign out_val = res_reg;
    assign out_ovf = ovf_reg;

endmodule

// ===== rtl/core/matrix4x4_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Loads A and B element by element and streams out the product A times B.
// ----------------------------------------------------------------------------
// in_stall is low only in the load state, where each transfer writes one
// element. A transfer with start_compute set runs a row of DIM cells, one
// per output row, that share a column of B: each column issues its
// products, drains them through the product and accumulator registers, then
// its DIM results shift out of the cell chain one per cycle while out_stall
// is low. No load is taken from the start transfer until the last column
// has been emitted.
// ----------------------------------------------------------------------------
module matrix4x4_multiply
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 matrix_sel,
    input  mm4_pkg::index_t      element_index,
    input  mm4_pkg::value_t      element_value,
    input  logic                 start_compute,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mm4_pkg::index_t      result_index,
    output mm4_pkg::value_t      result_value,
    output logic                 overflow,
    output logic                 last_result
);
    import mm4_pkg::*;

    localparam int CNT_W = $clog2(DIM + 3);
    localparam int RC_W  = $clog2(DIM);

    value_t     a_mem [CELLS];
    value_t     b_mem [CELLS];
    state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RC_W-1:0]  col_reg, col_next;
    logic [RC_W-1:0]  row_reg, row_next;
    cell_ctrl_t ctrl;
    logic       load_out;
    logic       shift_out;
    logic       in_xfer;
    logic [RC_W-1:0] k;
    value_t     b_cur;
    value_t     a_cur [DIM];
    value_t     cv [DIM+1];
    logic       co [DIM+1];

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_LOAD);
    assign k        = cnt_reg[RC_W-1:0];

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            if (matrix_sel)
                b_mem[element_index] <= element_value;
            else
                a_mem[element_index] <= element_value;
        end
    end

    // Operands for step k of column col: A[r + DIM*k], B[k + DIM*col].
    always_comb
    begin
        b_cur = b_mem[IDX_W'(k) + IDX_W'(DIM) * IDX_W'(col_reg)];
        for (int r = 0; r < DIM; r++)
            a_cur[r] = a_mem[IDX_W'(r) + IDX_W'(DIM) * IDX_W'(k)];
    end

    assign cv[DIM] = '0;
    assign co[DIM] = 1'b0;

    for (genvar r = 0; r < DIM; r++)
    begin : g_cell
        mm4_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .a_val     (a_cur[r]),
            .b_val     (b_cur),
            .load_out  (load_out),
            .shift_out (shift_out),
            .chain_val (cv[r+1]),
            .chain_ovf (co[r+1]),
            .out_val   (cv[r]),
            .out_ovf   (co[r])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        ctrl       = '0;
        load_out   = 1'b0;
        shift_out  = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer && start_compute)
                begin
                    state_next = ST_MAC;
                    cnt_next   = '0;
                    col_next   = '0;
                    ctrl.clear = 1'b1;
                end
            end
            ST_MAC:
            begin
                // Steps 0..DIM-1 issue products, two more drain the pipeline.
                ctrl.step = (cnt_reg < CNT_W'(DIM));
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIM + 1))
                begin
                    load_out   = 1'b1;
                    state_next = ST_EMIT;
                    row_next   = '0;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    shift_out = 1'b1;
                    row_next  = row_reg + 1'b1;
                    if (row_reg == RC_W'(DIM - 1))
                    begin
                        if (col_reg == RC_W'(DIM - 1))
                            state_next = ST_LOAD;
                        else
                        begin
                            state_next = ST_MAC;
                            cnt_next   = '0;
                            col_next   = col_reg + 1'b1;
                            ctrl.clear = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign result_index = IDX_W'(row_reg) + IDX_W'(DIM) * IDX_W'(col_reg);
    assign result_value = cv[0];
    assign overflow     = co[0];
    assign last_result  = (row_reg == RC_W'(DIM - 1)) && (col_reg == RC_W'(DIM - 1));

endmodule
